// ===== hdl/kces_pkg.sv =====
`default_nettype none
// ============================================================================
// kces_pkg: shared types and constants of the keypad code entry scanner
// Holds the phase enum, the state and result records, the key map and the
// register indexes used by the scanner top level and its step logic.
// ============================================================================
package kces_pkg;

   // Number of keys collected into one code.
   localparam int CODE_DIGITS = 4;

   localparam int SETTLE_W = 10;
   localparam int HOLD_W   = 20;
   localparam int ROWS_W   = 4;
   localparam int KEY_W    = 4;
   localparam int CODE_W   = 16;
   localparam int DIGIT_W  = 3;

   // Configuration register indexes.
   localparam logic CSR_SETTLE = 1'b0;
   localparam logic CSR_HOLD   = 1'b1;

   // Register values after reset.
   localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(20);
   localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(100000);

   localparam logic [DIGIT_W:0] DIGITS_LAST = (DIGIT_W + 1)'(CODE_DIGITS);

   typedef enum logic [1:0] {
      PH_SCAN,
      PH_SCAN_HOLD,
      PH_REL,
      PH_REL_HOLD
   } phase_type;

   typedef struct packed {
      phase_type           phase;
      logic [1:0]          column_index;
      logic [HOLD_W-1:0]   delay_count;
      logic                found_valid;
      logic [KEY_W-1:0]    found_key;
      logic                seen_pressed;
      logic [DIGIT_W-1:0]  digit_count;
      logic [CODE_W-1:0]   code_shift;
   } state_type;

   typedef struct packed {
      logic [2:0]          column_drive;
      logic                key_event;
      logic [KEY_W-1:0]    key_code;
      logic                code_ready;
      logic [CODE_W-1:0]   code_value;
   } result_type;

   // Lowest index among the pressed rows; the bottom row when only it or no row is set.
   function automatic logic [1:0] lowest_row(input logic [ROWS_W-1:0] rows);
      logic [1:0] row;
      priority if (rows[0]) row = 2'd0;
      else if (rows[1])     row = 2'd1;
      else if (rows[2])     row = 2'd2;
      else                  row = 2'd3;
      return row;
   endfunction

   // Key code under a column and a row (10 is star, 11 is pound).
   function automatic logic [KEY_W-1:0] key_map(input logic [1:0] col,
                                                input logic [1:0] row);
      logic [KEY_W-1:0] key;
      unique case ({col, row})
         4'b00_00: key = 4'd1;
         4'b00_01: key = 4'd4;
         4'b00_10: key = 4'd7;
         4'b00_11: key = 4'd10;
         4'b01_00: key = 4'd2;
         4'b01_01: key = 4'd5;
         4'b01_10: key = 4'd8;
         4'b01_11: key = 4'd0;
         4'b10_00: key = 4'd3;
         4'b10_01: key = 4'd6;
         4'b10_10: key = 4'd9;
         4'b10_11: key = 4'd11;
         default:  key = 4'd0;
      endcase
      return key;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/kces_step.sv =====
`default_nettype none
// ============================================================================
// kces_step: next-state and result logic for one scanner tick
// Takes the current state, the sensed rows and the timing registers and
// produces the state after the tick together with the tick's result.
// ============================================================================
module kces_step (
   input  kces_pkg::state_type                   state_cur,
   input  logic [kces_pkg::ROWS_W-1:0]           row_lines,
   input  logic [kces_pkg::SETTLE_W-1:0]         settle_ticks,
   input  logic [kces_pkg::HOLD_W-1:0]           hold_ticks,
   output kces_pkg::state_type                   state_nxt,
   output kces_pkg::result_type                  result
);
   import kces_pkg::*;

   logic [1:0]        col;
   logic              last_col;
   logic              settle_done;
   logic              hold_done;
   logic              rows_any;
   logic              rel_pressed;
   logic              code_full;
   logic [HOLD_W-1:0] delay_inc;
   logic [KEY_W-1:0]  sampled_key;
   phase_type         phase_nxt;

   // An out-of-range column index is treated as the left column.
   assign col         = (state_cur.column_index > 2'd2) ? 2'd0 : state_cur.column_index;
   assign last_col    = (col == 2'd2);
   assign settle_done = (state_cur.delay_count >= {{(HOLD_W-SETTLE_W){1'b0}}, settle_ticks});
   assign hold_done   = (state_cur.delay_count >= hold_ticks);
   assign rows_any    = (row_lines != '0);
   assign rel_pressed = state_cur.seen_pressed | rows_any;
   assign code_full   = (({1'b0, state_cur.digit_count} + (DIGIT_W + 1)'(1)) >= DIGITS_LAST);
   assign delay_inc   = state_cur.delay_count + HOLD_W'(1);
   assign sampled_key = key_map(col, lowest_row(row_lines));

   // Phase sequencing.
   always_comb begin
      phase_nxt = state_cur.phase;
      unique case (state_cur.phase)
         PH_SCAN: begin
            if (settle_done && last_col) phase_nxt = PH_SCAN_HOLD;
         end
         PH_SCAN_HOLD: begin
            if (hold_done) phase_nxt = state_cur.found_valid ? PH_REL : PH_SCAN;
         end
         PH_REL: begin
            if (last_col && !rel_pressed) phase_nxt = PH_REL_HOLD;
         end
         PH_REL_HOLD: begin
            if (hold_done) phase_nxt = PH_SCAN;
         end
         default: phase_nxt = PH_SCAN;
      endcase
   end

   // Counters, key capture and code collection.
   always_comb begin
      state_nxt             = state_cur;
      state_nxt.phase       = phase_nxt;
      result                = '0;
      result.column_drive   = 3'b001 << col;
      unique case (state_cur.phase)
         PH_SCAN: begin
            if (!settle_done) begin
               state_nxt.delay_count = delay_inc;
            end else begin
               if (rows_any) begin
                  state_nxt.found_key   = sampled_key;
                  state_nxt.found_valid = 1'b1;
               end
               state_nxt.delay_count  = '0;
               state_nxt.column_index = last_col ? 2'd0 : col + 2'd1;
            end
         end
         PH_SCAN_HOLD: begin
            if (!hold_done) begin
               state_nxt.delay_count = delay_inc;
            end else begin
               state_nxt.delay_count  = '0;
               state_nxt.column_index = 2'd0;
               if (state_cur.found_valid) begin
                  result.key_event       = 1'b1;
                  result.key_code        = state_cur.found_key;
                  state_nxt.code_shift   = {state_cur.code_shift[CODE_W-KEY_W-1:0],
                                            state_cur.found_key};
                  state_nxt.found_valid  = 1'b0;
                  state_nxt.seen_pressed = 1'b0;
               end
            end
         end
         PH_REL: begin
            if (last_col) begin
               state_nxt.column_index = 2'd0;
               state_nxt.seen_pressed = 1'b0;
               if (!rel_pressed) state_nxt.delay_count = '0;
            end else begin
               state_nxt.column_index = col + 2'd1;
               state_nxt.seen_pressed = rel_pressed;
            end
         end
         PH_REL_HOLD: begin
            if (!hold_done) begin
               state_nxt.delay_count = delay_inc;
            end else begin
               state_nxt.delay_count  = '0;
               state_nxt.column_index = 2'd0;
               if (code_full) begin
                  result.code_ready     = 1'b1;
                  result.code_value     = state_cur.code_shift;
                  state_nxt.code_shift  = '0;
                  state_nxt.digit_count = '0;
               end else begin
                  state_nxt.digit_count = state_cur.digit_count + DIGIT_W'(1);
               end
            end
         end
         default: state_nxt = state_cur;
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/keypad_code_entry_scanner.sv =====
`default_nettype none
// ============================================================================
// keypad_code_entry_scanner: 3x4 keypad scanner and code collector
// Drives the keypad columns, samples the rows and packs four keys into a code.
// ============================================================================
// Usage. Each transfer on the req_ channel is one timebase tick and carries the
// row lines sensed under the column that was being driven during that tick.
// Every accepted tick produces exactly one transfer on the rsp_ channel with
// the column drive for that tick, a key event with its code, and a finished
// code when the fourth key's release hold ends. The result appears in the cycle
// after the tick is accepted, from an output register.
// Throughput is one tick per clock: req_tready stays high while the output
// register is empty or being emptied in the same cycle, so a new tick can
// follow every cycle. When the receiver holds rsp_tready low, the output
// register keeps its result and req_tready drops until it is taken.
// The csr_ channel writes settle_ticks (index 0) and hold_ticks (index 1);
// it is always ready and a write takes effect at the next tick. Reset clears
// the scan state to the left column in the scan phase and loads the default
// timing values (20 settle ticks, 100000 hold ticks).
// ============================================================================
module keypad_code_entry_scanner (
   input  logic        clock,
   input  logic        reset,
   // Tick input. tdata: [3:0] row_lines, [7:4] zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Tick result. tdata: [2:0] column_drive, [6:3] key_code,
   // [22:7] code_value, [23] zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // tuser: [0] key_event, [1] code_ready.
   output logic [1:0]  rsp_tuser,
   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [19:0] csr_data
);
   import kces_pkg::*;

   state_type             state_ff;
   state_type             state_in;
   result_type            result_in;
   result_type            result_ff;
   logic                  rsp_valid_ff;
   logic [SETTLE_W-1:0]   settle_ff;
   logic [HOLD_W-1:0]     hold_ff;
   logic                  req_accept;
   logic                  csr_accept;

   // The output register may be refilled in the same cycle it is drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   kces_step u_step (
      .state_cur    (state_ff),
      .row_lines    (req_tdata[ROWS_W-1:0]),
      .settle_ticks (settle_ff),
      .hold_ticks   (hold_ff),
      .state_nxt    (state_in),
      .result       (result_in)
   );

   // Timing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
         hold_ff   <= HOLD_RESET;
      end else if (csr_accept) begin
         unique case (csr_index)
            CSR_SETTLE: settle_ff <= csr_data[SETTLE_W-1:0];
            CSR_HOLD:   hold_ff   <= csr_data[HOLD_W-1:0];
            default:    hold_ff   <= hold_ff;
         endcase
      end
   end

   // Scanner state advances once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_SCAN, default: '0};
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.code_value, result_ff.key_code,
                        result_ff.column_drive};
   assign rsp_tuser  = {result_ff.code_ready, result_ff.key_event};

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the keypad code entry scanner
// Feeds row-sense ticks from a simulated keypad, predicts every result with a
// cycle-free model of the scanner and checks each rsp_ transfer field by field
// under random idling on both sides and several timing register settings.
// ============================================================================
module tb;
   import kces_pkg::*;

   // Key codes that do not follow the digit grid.
   localparam logic [3:0] KEY_ZERO  = 4'd0;
   localparam logic [3:0] KEY_STAR  = 4'd10;
   localparam logic [3:0] KEY_POUND = 4'd11;

   localparam logic [1:0] COL_LEFT   = 2'd0;
   localparam logic [1:0] COL_MIDDLE = 2'd1;
   localparam logic [1:0] COL_RIGHT  = 2'd2;
   localparam logic [1:0] ROW_BOTTOM = 2'd3;

   localparam int PHASES = 7;
   localparam int LONG_HOLDOFF = 150;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [19:0] csr_data;

   keypad_code_entry_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Scanner prediction. The model holds its own copy of the scan state and of
   // the two timing registers, and advances by one tick per accepted transfer.
   // -------------------------------------------------------------------------
   state_type          scan_state;
   logic [SETTLE_W-1:0] settle_cfg;
   logic [HOLD_W-1:0]   hold_cfg;
   result_type         predicted_outputs [$];

   int error_count    = 0;
   int ticks_sent     = 0;
   int keys_accepted  = 0;
   int codes_emitted  = 0;
   int settings_used  = 0;

   // The three upper rows count up across the columns; the bottom row holds
   // star, zero and pound.
   function automatic logic [3:0] key_at(input logic [1:0] col, input logic [1:0] row);
      logic [3:0] key;
      if (row != ROW_BOTTOM) key = 4'(3 * row + col + 1);
      else if (col == COL_LEFT) key = KEY_STAR;
      else if (col == COL_MIDDLE) key = KEY_ZERO;
      else key = KEY_POUND;
      return key;
   endfunction

   // The topmost pressed row decides; with nothing pressed the bottom row is
   // reported, but the caller only asks when some row is set.
   function automatic logic [1:0] top_pressed_row(input logic [3:0] rows);
      logic [1:0] row;
      row = ROW_BOTTOM;
      for (int r = 3; r >= 0; r--) begin
         if (rows[r]) row = 2'(r);
      end
      return row;
   endfunction

   function automatic result_type advance_scanner(input logic [3:0] rows);
      result_type res;
      logic [1:0] col;
      res = '0;
      col = (scan_state.column_index > COL_RIGHT) ? COL_LEFT : scan_state.column_index;
      res.column_drive = 3'b001 << col;
      case (scan_state.phase)
         PH_SCAN: begin
            if (scan_state.delay_count < HOLD_W'(settle_cfg)) begin
               scan_state.delay_count = scan_state.delay_count + 1'b1;
            end else begin
               // A later column simply overwrites what an earlier one found.
               if (rows != 4'd0) begin
                  scan_state.found_key   = key_at(col, top_pressed_row(rows));
                  scan_state.found_valid = 1'b1;
               end
               scan_state.delay_count = '0;
               if (col >= COL_RIGHT) begin
                  scan_state.column_index = COL_LEFT;
                  scan_state.phase = PH_SCAN_HOLD;
               end else begin
                  scan_state.column_index = col + 1'b1;
               end
            end
         end
         PH_SCAN_HOLD: begin
            if (scan_state.delay_count < hold_cfg) begin
               scan_state.delay_count = scan_state.delay_count + 1'b1;
            end else begin
               scan_state.delay_count  = '0;
               scan_state.column_index = COL_LEFT;
               if (scan_state.found_valid) begin
                  res.key_event = 1'b1;
                  res.key_code  = scan_state.found_key;
                  scan_state.code_shift   = {scan_state.code_shift[11:0], scan_state.found_key};
                  scan_state.found_valid  = 1'b0;
                  scan_state.seen_pressed = 1'b0;
                  scan_state.phase = PH_REL;
                  keys_accepted++;
               end else begin
                  scan_state.phase = PH_SCAN;
               end
            end
         end
         PH_REL: begin
            // One tick per column; any press restarts the release pass.
            if (rows != 4'd0) scan_state.seen_pressed = 1'b1;
            if (col >= COL_RIGHT) begin
               scan_state.column_index = COL_LEFT;
               if (scan_state.seen_pressed) begin
                  scan_state.seen_pressed = 1'b0;
               end else begin
                  scan_state.delay_count = '0;
                  scan_state.phase = PH_REL_HOLD;
               end
            end else begin
               scan_state.column_index = col + 1'b1;
            end
         end
         default: begin
            if (scan_state.delay_count < hold_cfg) begin
               scan_state.delay_count = scan_state.delay_count + 1'b1;
            end else begin
               scan_state.delay_count  = '0;
               scan_state.column_index = COL_LEFT;
               if (scan_state.digit_count + 1 >= CODE_DIGITS) begin
                  res.code_ready = 1'b1;
                  res.code_value = scan_state.code_shift;
                  scan_state.code_shift  = '0;
                  scan_state.digit_count = '0;
                  codes_emitted++;
               end else begin
                  scan_state.digit_count = scan_state.digit_count + 1'b1;
               end
               scan_state.phase = PH_SCAN;
            end
         end
      endcase
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Simulated keypad. A press episode holds one or a few keys for a while and
   // then releases them; the row lines follow the column the scanner drives,
   // which the model knows before each tick. Some ticks carry random noise
   // instead, which also produces bounces during the release pass.
   // -------------------------------------------------------------------------
   logic [3:0] held_rows [3];
   int press_left   = 0;
   int release_left = 0;

   task automatic next_keypad_rows(output logic [3:0] rows);
      int span;
      int keys;
      logic [1:0] col;
      span = 3 * (int'(settle_cfg) + 1) + ((hold_cfg > 40) ? 40 : int'(hold_cfg)) + 4;
      col = (scan_state.column_index > COL_RIGHT) ? COL_LEFT : scan_state.column_index;
      if (press_left == 0 && release_left == 0) begin
         for (int c = 0; c < 3; c++) held_rows[c] = 4'd0;
         keys = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : 1;
         repeat (keys) held_rows[$urandom_range(0, 2)][$urandom_range(0, 3)] = 1'b1;
         press_left   = $urandom_range(1, 2 * span);
         release_left = $urandom_range(1, span + 4);
      end
      if ($urandom_range(0, 7) == 0) begin
         rows = 4'($urandom_range(0, 15));
      end else if (press_left > 0) begin
         rows = held_rows[col];
      end else begin
         rows = 4'd0;
      end
      if (press_left > 0) press_left--;
      else release_left--;
   endtask

   // -------------------------------------------------------------------------
   // Sender side. Every task below is entered right after a rising edge.
   // -------------------------------------------------------------------------
   bit tx_quiet   = 1'b0;
   bit rx_quiet   = 1'b0;
   bit rx_holding = 1'b0;

   // Offers one tick; once the transfer happens the model advances and its
   // result, or the typed-in one, joins the queue of predicted outputs.
   task automatic send_tick(input logic [3:0] rows, input logic typed, input result_type want);
      int gap;
      result_type res;
      if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
      // While the receiver holds off, keep offering so the block backs up.
      gap = (tx_quiet || rx_holding) ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, rows};
      do @(posedge clock); while (!req_tready);
      res = advance_scanner(rows);
      predicted_outputs.push_back(typed ? want : res);
      ticks_sent++;
   endtask

   // Register writes go in only when every predicted result has been taken.
   // Each tick gives exactly one result, so an empty queue means the block is idle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Writes both timing registers back to back, valid staying high in between.
   task automatic set_timing(input logic [19:0] settle_word, input logic [19:0] hold_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_SETTLE;
      csr_data  <= settle_word;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_HOLD;
      csr_data  <= hold_word;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settle_cfg = settle_word[SETTLE_W-1:0];
      hold_cfg   = hold_word;
      settings_used++;
   endtask

   // -------------------------------------------------------------------------
   // Directed plan: a timing write or one tick per row. Expected results are
   // typed in where they are plain (right after reset and on key events);
   // the other rows are checked against the model.
   // -------------------------------------------------------------------------
   typedef struct packed {
      logic        timing;
      logic [19:0] settle_word;
      logic [19:0] hold_word;
      logic [3:0]  rows;
      logic        typed;
      result_type  want;
   } plan_row_type;

   function automatic plan_row_type tick_row(input logic [3:0] rows, input logic typed,
                                             input logic [2:0] col, input logic ev,
                                             input logic [3:0] key);
      plan_row_type r;
      r = '0;
      r.rows  = rows;
      r.typed = typed;
      r.want.column_drive = col;
      r.want.key_event    = ev;
      r.want.key_code     = key;
      return r;
   endfunction

   function automatic plan_row_type timing_row(input logic [19:0] settle_word,
                                               input logic [19:0] hold_word);
      plan_row_type r;
      r = '0;
      r.timing      = 1'b1;
      r.settle_word = settle_word;
      r.hold_word   = hold_word;
      return r;
   endfunction

   plan_row_type directed_plan [23];

   // Random phases: settle, hold and tick count. The longest hold runs only a
   // few dozen ticks and leaves the count high, so the next phase's shorter
   // hold meets a count already past its limit. The longest settle also stops
   // after a few dozen ticks, so the zero settle that follows meets a count
   // well beyond its limit.
   int phase_settle [PHASES] = '{0, 2, 5, 1, 1023, 0, 3};
   int phase_hold   [PHASES] = '{0, 1, 1048575, 0, 2, 4, 2};
   int phase_ticks  [PHASES] = '{190, 190, 60, 190, 80, 190, 300};

   // -------------------------------------------------------------------------
   // Main stimulus.
   // -------------------------------------------------------------------------
   initial begin
      logic [3:0]  rows;
      logic [19:0] settle_word;
      logic [19:0] hold_word;
      int          sent;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_SETTLE;
      csr_data   <= '0;
      scan_state = '0;
      settle_cfg = SETTLE_RESET;
      hold_cfg   = HOLD_RESET;

      // Default timing first: rows are ignored while the column settles.
      directed_plan[0]  = tick_row(4'hF, 1'b1, 3'b001, 1'b0, 4'd0);
      directed_plan[1]  = tick_row(4'h0, 1'b1, 3'b001, 1'b0, 4'd0);
      directed_plan[2]  = tick_row(4'h5, 1'b1, 3'b001, 1'b0, 4'd0);
      // Zero settle and hold while the settle count is already past zero.
      directed_plan[3]  = timing_row(20'd0, 20'd0);
      // Star in the left column, then two rows in the middle column: the top
      // one wins there and overrides the star.
      directed_plan[4]  = tick_row(4'h8, 1'b0, 3'b000, 1'b0, 4'd0);
      directed_plan[5]  = tick_row(4'h6, 1'b0, 3'b000, 1'b0, 4'd0);
      directed_plan[6]  = tick_row(4'h0, 1'b0, 3'b000, 1'b0, 4'd0);
      directed_plan[7]  = tick_row(4'hF, 1'b1, 3'b001, 1'b1, 4'd5);
      // A press in the release pass restarts it from the left column.
      directed_plan[8]  = tick_row(4'h1, 1'b0, 3'b000, 1'b0, 4'd0);
      for (int i = 9; i <= 14; i++) directed_plan[i] = tick_row(4'h0, 1'b0, 3'b000, 1'b0, 4'd0);
      // Zero in the middle column, overridden by 3 in the right column.
      directed_plan[15] = tick_row(4'h0, 1'b0, 3'b000, 1'b0, 4'd0);
      directed_plan[16] = tick_row(4'h8, 1'b0, 3'b000, 1'b0, 4'd0);
      directed_plan[17] = tick_row(4'h9, 1'b0, 3'b000, 1'b0, 4'd0);
      directed_plan[18] = tick_row(4'h0, 1'b1, 3'b001, 1'b1, 4'd3);
      for (int i = 19; i <= 22; i++) directed_plan[i] = tick_row(4'h0, 1'b0, 3'b000, 1'b0, 4'd0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].timing) begin
            wait_drained();
            set_timing(directed_plan[i].settle_word, directed_plan[i].hold_word);
         end else begin
            send_tick(directed_plan[i].rows, directed_plan[i].typed, directed_plan[i].want);
         end
      end

      // Random part, one timing setting per phase. The last phase draws its
      // own short timing and runs on a little while few codes have come out.
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         settle_word = {10'($urandom), 10'(phase_settle[p])};
         hold_word   = 20'(phase_hold[p]);
         if (p == PHASES - 1) begin
            settle_word[SETTLE_W-1:0] = 10'($urandom_range(0, 3));
            hold_word = 20'($urandom_range(0, 6));
         end
         set_timing(settle_word, hold_word);
         sent = 0;
         while (sent < phase_ticks[p] ||
                (p == PHASES - 1 && codes_emitted < 12 && sent < 360)) begin
            next_keypad_rows(rows);
            send_tick(rows, 1'b0, '0);
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d ticks under %0d timing settings, including both register extremes.",
               ticks_sent, settings_used + 1);
      $display("Predicted %0d key events and %0d finished codes; %0d mismatches.",
               keys_accepted, codes_emitted, error_count);
      if (error_count == 0) begin
         $display("keypad_code_entry_scanner test passed");
      end else begin
         $display("keypad_code_entry_scanner test failed");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver side: a random stall before each transfer, quiet stretches with
   // no stall, and two long hold-offs that fill the output register so that
   // req_tready has to drop while the sender keeps offering ticks.
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
         if (taken == 300 || taken == 900) begin
            rx_holding = 1'b1;
            stall = LONG_HOLDOFF;
         end else begin
            stall = rx_quiet ? 0 : $urandom_range(0, 19);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rx_holding = 1'b0;
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   // -------------------------------------------------------------------------
   // Result check: every rsp_ transfer against the oldest prediction.
   // -------------------------------------------------------------------------
   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_outputs.size() == 0) begin
            $display("%0t ns: result transfer with none expected, tdata 0x%0h tuser 0x%0h",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = predicted_outputs.pop_front();
            check_field("column_drive", 16'(want.column_drive), 16'(rsp_tdata[2:0]));
            check_field("key_code", 16'(want.key_code), 16'(rsp_tdata[6:3]));
            check_field("code_value", want.code_value, rsp_tdata[22:7]);
            check_field("tdata pad bit", 16'd0, 16'(rsp_tdata[23]));
            check_field("key_event", 16'(want.key_event), 16'(rsp_tuser[0]));
            check_field("code_ready", 16'(want.code_ready), 16'(rsp_tuser[1]));
         end
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Timeout with %0d results still expected.", predicted_outputs.size());
      $display("keypad_code_entry_scanner test failed");
      $finish;
   end

endmodule
